>>> design/charset_to_utf8_converter_assert.svh
// Assertion macros for the charset converter.
`ifndef CHARSET_TO_UTF8_CONVERTER_ASSERT_SVH
`define CHARSET_TO_UTF8_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define C2U_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define C2U_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define C2U_ASSERT(name, prop, msg)
`define C2U_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

>>> design/c2u_pkg.sv
package c2u_pkg;

    typedef enum logic [1:0] {
        MODE_EBU   = 2'd0,
        MODE_UTF16 = 2'd1,
        MODE_PASS  = 2'd2
    } t_mode;

    // up to four UTF-8 bytes produced by one item, bytes[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
        logic            err;
    } t_burst;

    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    // EBU Latin character set to code point
    localparam logic [15:0] EBU_ROM [256] = '{
        16'h0000, 16'h0118, 16'h012e, 16'h0172, 16'h0102, 16'h0116, 16'h010e, 16'h0218,
        16'h021a, 16'h010a, 16'h000a, 16'h000b, 16'h0120, 16'h0139, 16'h017b, 16'h0143,
        16'h0105, 16'h0119, 16'h012f, 16'h0173, 16'h0103, 16'h0117, 16'h010f, 16'h0219,
        16'h021b, 16'h010b, 16'h0147, 16'h011a, 16'h0121, 16'h013a, 16'h017c, 16'h0082,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0142, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005a, 16'h005b, 16'h016e, 16'h005d, 16'h0141, 16'h005f,
        16'h0104, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007a, 16'h00ab, 16'h016f, 16'h00bb, 16'h013d, 16'h0126,
        16'h00e1, 16'h00e0, 16'h00e9, 16'h00e8, 16'h00ed, 16'h00ec, 16'h00f3, 16'h00f2,
        16'h00fa, 16'h00f9, 16'h00d1, 16'h00c7, 16'h015e, 16'h00df, 16'h00a1, 16'h0178,
        16'h00e2, 16'h00e4, 16'h00ea, 16'h00eb, 16'h00ee, 16'h00ef, 16'h00f4, 16'h00f6,
        16'h00fb, 16'h00fc, 16'h00f1, 16'h00e7, 16'h015f, 16'h011f, 16'h0131, 16'h00ff,
        16'h0136, 16'h0145, 16'h00a9, 16'h0122, 16'h011e, 16'h011b, 16'h0148, 16'h0151,
        16'h0150, 16'h20ac, 16'h00a3, 16'h0024, 16'h0100, 16'h0112, 16'h012a, 16'h016a,
        16'h0137, 16'h0146, 16'h013b, 16'h0123, 16'h013c, 16'h0130, 16'h0144, 16'h0171,
        16'h0170, 16'h00bf, 16'h013e, 16'h00b0, 16'h0101, 16'h0113, 16'h012b, 16'h016b,
        16'h00c1, 16'h00c0, 16'h00c9, 16'h00c8, 16'h00cd, 16'h00cc, 16'h00d3, 16'h00d2,
        16'h00da, 16'h00d9, 16'h0158, 16'h010c, 16'h0160, 16'h017d, 16'h00d0, 16'h013f,
        16'h00c2, 16'h00c4, 16'h00ca, 16'h00cb, 16'h00ce, 16'h00cf, 16'h00d4, 16'h00d6,
        16'h00db, 16'h00dc, 16'h0159, 16'h010d, 16'h0161, 16'h017e, 16'h0111, 16'h0140,
        16'h00c3, 16'h00c5, 16'h00c6, 16'h0152, 16'h0177, 16'h00dd, 16'h00d5, 16'h00d8,
        16'h00de, 16'h014a, 16'h0154, 16'h0106, 16'h015a, 16'h0179, 16'h0164, 16'h00f0,
        16'h00e3, 16'h00e5, 16'h00e6, 16'h0153, 16'h0175, 16'h00fd, 16'h00f5, 16'h00f8,
        16'h00fe, 16'h014b, 16'h0155, 16'h0107, 16'h015b, 16'h017a, 16'h0165, 16'h0127
    };

    function automatic t_burst encode_cp(input logic [20:0] cp, input logic last);
        t_burst b;
        b      = '0;
        b.last = last;
        if (cp < 21'h80) begin
            b.bytes[0] = cp[7:0];
            b.count    = 3'd1;
        end else if (cp < 21'h800) begin
            b.bytes[0] = {3'b110, cp[10:6]};
            b.bytes[1] = {2'b10, cp[5:0]};
            b.count    = 3'd2;
        end else if (cp < 21'h10000) begin
            b.bytes[0] = {4'b1110, cp[15:12]};
            b.bytes[1] = {2'b10, cp[11:6]};
            b.bytes[2] = {2'b10, cp[5:0]};
            b.count    = 3'd3;
        end else begin
            b.bytes[0] = {5'b11110, cp[20:18]};
            b.bytes[1] = {2'b10, cp[17:12]};
            b.bytes[2] = {2'b10, cp[11:6]};
            b.bytes[3] = {2'b10, cp[5:0]};
            b.count    = 3'd4;
        end
        return b;
    endfunction

    function automatic t_burst error_burst();
        t_burst b;
        b       = '0;
        b.count = 3'd1;
        b.last  = 1'b1;
        b.err   = 1'b1;
        return b;
    endfunction

endpackage

>>> design/c2u_front.sv
module c2u_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c2u_pkg::t_mode    i_mode,
    input  logic [15:0]       i_unit,
    input  logic              i_last,
    input  logic              i_valid,
    output logic              o_ready,
    output c2u_pkg::t_burst   o_burst,
    output logic              o_burst_valid,
    input  logic              i_burst_ready
);

    logic [15:0] r_unit;
    logic        r_last;
    logic        r_in_valid;

    logic [9:0]  r_hi_bits, n_hi_bits;
    logic        r_hi_valid, n_hi_valid;
    logic        r_failed, n_failed;

    logic        advance;
    logic        is_high, is_low;
    logic [20:0] pair_cp;
    c2u_pkg::t_burst burst;

    assign advance       = r_in_valid && i_burst_ready;
    assign o_ready       = !r_in_valid || i_burst_ready;
    assign o_burst_valid = r_in_valid;
    assign o_burst       = burst;

    assign is_high = r_unit[15:10] == c2u_pkg::SURR_HIGH;
    assign is_low  = r_unit[15:10] == c2u_pkg::SURR_LOW;
    assign pair_cp = {1'b0, r_hi_bits, r_unit[9:0]} + 21'h10000;

    always_comb begin
        burst      = '0;
        burst.last = r_last;
        n_hi_bits  = r_hi_bits;
        n_hi_valid = r_hi_valid;
        n_failed   = r_failed;
        if (!r_failed) begin
            case (i_mode)
                c2u_pkg::MODE_PASS: begin
                    burst.bytes[0] = r_unit[7:0];
                    burst.count    = 3'd1;
                end
                c2u_pkg::MODE_UTF16: begin
                    if (r_hi_valid ? is_low : !(is_low || (is_high && r_last))) begin
                        if (r_hi_valid) begin
                            burst      = c2u_pkg::encode_cp(pair_cp, r_last);
                            n_hi_valid = 1'b0;
                        end else if (is_high) begin
                            n_hi_bits  = r_unit[9:0];
                            n_hi_valid = 1'b1;
                        end else begin
                            burst = c2u_pkg::encode_cp({5'd0, r_unit}, r_last);
                        end
                    end else begin
                        // bad surrogate sequence: one error byte, drop until last
                        burst      = c2u_pkg::error_burst();
                        n_hi_valid = 1'b0;
                        n_failed   = !r_last;
                    end
                end
                default: begin
                    burst = c2u_pkg::encode_cp({5'd0, c2u_pkg::EBU_ROM[r_unit[7:0]]},
                                               r_last);
                end
            endcase
        end
        if (r_last) begin
            n_failed   = 1'b0;
            n_hi_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_hi_valid <= 1'b0;
            r_failed   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_hi_valid <= n_hi_valid;
                r_failed   <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_unit <= i_unit;
            r_last <= i_last;
        end
        if (advance) begin
            r_hi_bits <= n_hi_bits;
        end
    end

endmodule

>>> design/c2u_serial.sv
module c2u_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c2u_pkg::t_burst   i_burst,
    input  logic              i_burst_valid,
    output logic              o_burst_ready,
    output logic [7:0]        o_byte,
    output logic              o_last,
    output logic              o_err,
    output logic              o_valid,
    input  logic              i_ready
);

    logic [3:0][7:0] r_bytes;
    logic [2:0]      r_rem;
    logic [1:0]      r_pos;
    logic            r_last;
    logic            r_err;
    logic            take;

    assign o_valid       = r_rem != 3'd0;
    assign take          = o_valid && i_ready;
    assign o_burst_ready = (r_rem == 3'd0) || (r_rem == 3'd1 && i_ready);
    assign o_byte        = r_bytes[r_pos];
    assign o_last        = r_last && (r_rem == 3'd1);
    assign o_err         = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
            r_pos <= 2'd0;
        end else if (i_burst_valid && o_burst_ready) begin
            r_rem <= i_burst.count;
            r_pos <= 2'd0;
        end else if (take) begin
            r_rem <= r_rem - 3'd1;
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst_valid && o_burst_ready) begin
            r_bytes <= i_burst.bytes;
            r_last  <= i_burst.last;
            r_err   <= i_burst.err;
        end
    end

endmodule

>>> design/charset_to_utf8_converter.sv
// Text stream to UTF-8 converter.
// Input channel (i_in_valid / o_in_ready) takes one character unit per item:
// a byte in EBU Latin and UTF-8 passthrough modes, a 16-bit unit in UTF-16
// mode; i_last_unit marks the end of a string. Output channel
// (o_out_valid / i_out_ready) gives one UTF-8 byte per item, o_last_byte on
// the final byte of a string and o_error_code on a bad surrogate sequence.
// i_cfg_we writes the charset mode; write it only while the block is idle.
// The first byte of an item is valid once the item has passed the input
// register and then the output register. Throughput: one output byte per
// cycle while the receiver is ready; an item yielding no bytes still passes
// through the output register, which holds up to four bytes of one item.
// Reset clears the mode to EBU Latin, any held high surrogate, the error
// state and both the input and output stages.
// When the receiver stalls, the current byte holds; one more item waits in
// the input register and then o_in_ready drops.
`include "charset_to_utf8_converter_assert.svh"

module charset_to_utf8_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic        o_error_code
);

    c2u_pkg::t_mode  r_mode;
    c2u_pkg::t_burst burst;
    logic            burst_valid;
    logic            burst_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= c2u_pkg::MODE_EBU;
        end else if (i_cfg_we) begin
            r_mode <= c2u_pkg::t_mode'(i_cfg_wdata);
        end
    end

    c2u_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_mode),
        .i_unit        (i_code_unit),
        .i_last        (i_last_unit),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .o_burst       (burst),
        .o_burst_valid (burst_valid),
        .i_burst_ready (burst_ready)
    );

    c2u_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst       (burst),
        .i_burst_valid (burst_valid),
        .o_burst_ready (burst_ready),
        .o_byte        (o_out_byte),
        .o_last        (o_last_byte),
        .o_err         (o_error_code),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready)
    );

    `C2U_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `C2U_ASSERT(a_err_last, o_out_valid && o_error_code |-> o_last_byte, "error byte not last")
    `C2U_ASSERT(a_err_zero, o_out_valid && o_error_code |-> o_out_byte == 8'd0, "error byte not zero")

endmodule

>>> sim/tb_top.sv
module tb_top;

    // mode 3 is not in the package enum; the block treats it as EBU Latin
    localparam logic [1:0] MODE_ALIAS    = 2'd3;
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // EBU Latin byte to code point
    localparam logic [15:0] LATIN_TO_CP [256] = '{
        16'h0000, 16'h0118, 16'h012e, 16'h0172, 16'h0102, 16'h0116, 16'h010e, 16'h0218,
        16'h021a, 16'h010a, 16'h000a, 16'h000b, 16'h0120, 16'h0139, 16'h017b, 16'h0143,
        16'h0105, 16'h0119, 16'h012f, 16'h0173, 16'h0103, 16'h0117, 16'h010f, 16'h0219,
        16'h021b, 16'h010b, 16'h0147, 16'h011a, 16'h0121, 16'h013a, 16'h017c, 16'h0082,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0142, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005a, 16'h005b, 16'h016e, 16'h005d, 16'h0141, 16'h005f,
        16'h0104, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007a, 16'h00ab, 16'h016f, 16'h00bb, 16'h013d, 16'h0126,
        16'h00e1, 16'h00e0, 16'h00e9, 16'h00e8, 16'h00ed, 16'h00ec, 16'h00f3, 16'h00f2,
        16'h00fa, 16'h00f9, 16'h00d1, 16'h00c7, 16'h015e, 16'h00df, 16'h00a1, 16'h0178,
        16'h00e2, 16'h00e4, 16'h00ea, 16'h00eb, 16'h00ee, 16'h00ef, 16'h00f4, 16'h00f6,
        16'h00fb, 16'h00fc, 16'h00f1, 16'h00e7, 16'h015f, 16'h011f, 16'h0131, 16'h00ff,
        16'h0136, 16'h0145, 16'h00a9, 16'h0122, 16'h011e, 16'h011b, 16'h0148, 16'h0151,
        16'h0150, 16'h20ac, 16'h00a3, 16'h0024, 16'h0100, 16'h0112, 16'h012a, 16'h016a,
        16'h0137, 16'h0146, 16'h013b, 16'h0123, 16'h013c, 16'h0130, 16'h0144, 16'h0171,
        16'h0170, 16'h00bf, 16'h013e, 16'h00b0, 16'h0101, 16'h0113, 16'h012b, 16'h016b,
        16'h00c1, 16'h00c0, 16'h00c9, 16'h00c8, 16'h00cd, 16'h00cc, 16'h00d3, 16'h00d2,
        16'h00da, 16'h00d9, 16'h0158, 16'h010c, 16'h0160, 16'h017d, 16'h00d0, 16'h013f,
        16'h00c2, 16'h00c4, 16'h00ca, 16'h00cb, 16'h00ce, 16'h00cf, 16'h00d4, 16'h00d6,
        16'h00db, 16'h00dc, 16'h0159, 16'h010d, 16'h0161, 16'h017e, 16'h0111, 16'h0140,
        16'h00c3, 16'h00c5, 16'h00c6, 16'h0152, 16'h0177, 16'h00dd, 16'h00d5, 16'h00d8,
        16'h00de, 16'h014a, 16'h0154, 16'h0106, 16'h015a, 16'h0179, 16'h0164, 16'h00f0,
        16'h00e3, 16'h00e5, 16'h00e6, 16'h0153, 16'h0175, 16'h00fd, 16'h00f5, 16'h00f8,
        16'h00fe, 16'h014b, 16'h0155, 16'h0107, 16'h015b, 16'h017a, 16'h0165, 16'h0127
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_utf8_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_code_unit;
    logic        i_last_unit;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic        o_error_code;

    // converter state as seen by the testbench
    logic [1:0]  conv_mode       = c2u_pkg::MODE_EBU;
    logic [9:0]  held_high_bits  = '0;
    logic        held_high_valid = 1'b0;
    logic        stream_failed   = 1'b0;

    t_utf8_out   expected_bytes [$];
    t_utf8_out   want;
    bit          idle_en;
    int          ready_hold    = 0;
    int          units_sent    = 0;
    int          live_units    = 0;
    int          bytes_checked = 0;
    int          error_results = 0;
    int          mismatches    = 0;

    charset_to_utf8_converter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_code_unit  (i_code_unit),
        .i_last_unit  (i_last_unit),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte),
        .o_error_code (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void push_code_point(input logic [20:0] cp, input logic last);
        logic [7:0] seq [4];
        int         n;
        int         k;
        if (cp < 21'h80) begin
            n      = 1;
            seq[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            n      = 2;
            seq[0] = 8'hC0 | cp[10:6];
            seq[1] = 8'h80 | cp[5:0];
        end else if (cp < 21'h10000) begin
            n      = 3;
            seq[0] = 8'hE0 | cp[15:12];
            seq[1] = 8'h80 | cp[11:6];
            seq[2] = 8'h80 | cp[5:0];
        end else begin
            n      = 4;
            seq[0] = 8'hF0 | cp[20:18];
            seq[1] = 8'h80 | cp[17:12];
            seq[2] = 8'h80 | cp[11:6];
            seq[3] = 8'h80 | cp[5:0];
        end
        for (k = 0; k < n; k++) begin
            expected_bytes.push_back('{data: seq[k], last: last && (k == n - 1), err: 1'b0});
        end
    endfunction

    function automatic void push_surrogate_error(input logic last);
        expected_bytes.push_back('{data: 8'h00, last: 1'b1, err: 1'b1});
        held_high_valid = 1'b0;
        held_high_bits  = '0;
        if (!last) begin
            stream_failed = 1'b1;
        end
    endfunction

    function automatic void predict_unit(input logic [15:0] unit, input logic last);
        logic is_high;
        logic is_low;
        is_high = unit[15:10] == HIGH_SURR_TAG;
        is_low  = unit[15:10] == LOW_SURR_TAG;
        if (!stream_failed) begin
            live_units++;
        end
        if (stream_failed) begin
            // dropped until the end of the string
        end else if (conv_mode == c2u_pkg::MODE_PASS) begin
            expected_bytes.push_back('{data: unit[7:0], last: last, err: 1'b0});
        end else if (conv_mode == c2u_pkg::MODE_UTF16) begin
            if (held_high_valid) begin
                if (is_low) begin
                    held_high_valid = 1'b0;
                    push_code_point(21'h10000 + {held_high_bits, unit[9:0]}, last);
                    held_high_bits = '0;
                end else begin
                    push_surrogate_error(last);
                end
            end else if (is_low) begin
                push_surrogate_error(last);
            end else if (is_high) begin
                if (last) begin
                    push_surrogate_error(last);
                end else begin
                    held_high_bits  = unit[9:0];
                    held_high_valid = 1'b1;
                end
            end else begin
                push_code_point({5'd0, unit}, last);
            end
        end else begin
            push_code_point({5'd0, LATIN_TO_CP[unit[7:0]]}, last);
        end
        if (last) begin
            stream_failed   = 1'b0;
            held_high_valid = 1'b0;
            held_high_bits  = '0;
        end
    endfunction

    // output check first, then the new item: a byte leaving now belongs to an older item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected byte %02h last %0b err %0b", $realtime,
                                 o_out_byte, o_last_byte, o_error_code);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (want.err) begin
                        error_results++;
                    end
                    if ({o_out_byte, o_last_byte, o_error_code} !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected byte %02h last %0b err %0b, got %02h %0b %0b",
                                     $realtime, want.data, want.last, want.err,
                                     o_out_byte, o_last_byte, o_error_code);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_unit(i_code_unit, i_last_unit);
            end
            if (i_cfg_we) begin
                conv_mode = i_cfg_wdata;
            end
        end
    end

    // receiver: random stalls between ready stretches, only while idle_en is set
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
        end else if (idle_en && $urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold = $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
    end

    // entered at a rising edge; valid stays high on return
    task automatic send_unit(input logic [15:0] unit, input logic last);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_code_unit <= unit;
        i_last_unit <= last;
        do @(posedge i_clk); while (!o_in_ready);
        units_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        // items with no output may still be in the input stage
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // reset mode: one, two and three byte code points, byte zero, upper byte ignored
    task automatic test_ebu_table();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0001, 1'b0);
        send_unit(16'h00A9, 1'b0);
        send_unit(16'h00FF, 1'b0);
        send_unit(16'hAB5C, 1'b1);
    endtask

    task automatic test_utf16_pairs();
        write_mode(c2u_pkg::MODE_UTF16);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
    endtask

    task automatic test_surrogate_errors();
        // lone low, then the rest of the string is dropped
        send_unit(16'hDC00, 1'b0);
        send_unit(16'h0042, 1'b1);
        // high after high, on the last unit
        send_unit(16'hD800, 1'b0);
        send_unit(16'hD801, 1'b1);
        // scalar after high, failed until last
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0000, 1'b1);
        // high surrogate marked last
        send_unit(16'hD800, 1'b1);
    endtask

    // a held high surrogate survives a trip through another mode
    task automatic test_held_across_modes();
        send_unit(16'hD83D, 1'b0);
        write_mode(c2u_pkg::MODE_EBU);
        send_unit(16'h0041, 1'b0);
        write_mode(c2u_pkg::MODE_UTF16);
        send_unit(16'hDE00, 1'b1);
    endtask

    task automatic test_passthrough();
        write_mode(c2u_pkg::MODE_PASS);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hFF80, 1'b0);
        send_unit(16'h007F, 1'b1);
    endtask

    task automatic test_mode_alias();
        write_mode(MODE_ALIAS);
        send_unit(16'h00A9, 1'b1);
    endtask

    task automatic random_byte_units(input int n);
        int start;
        start = live_units;
        while (live_units - start < n) begin
            send_unit(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 7) == 0);
        end
    endtask

    // mostly well-formed text: scalars and complete pairs, a few stray surrogates
    task automatic random_utf16_units(input int n);
        int          start;
        int          kind;
        logic [15:0] u;
        start = live_units;
        while (live_units - start < n) begin
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
                case ($urandom_range(0, 3))
                    0:       u = 16'($urandom_range(0, 16'h007F));
                    1:       u = 16'($urandom_range(16'h0080, 16'h07FF));
                    2:       u = 16'($urandom_range(16'h0800, 16'hD7FF));
                    default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
                endcase
                send_unit(u, $urandom_range(0, 5) == 0);
            end else if (kind < 19) begin
                send_unit({HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
                send_unit({LOW_SURR_TAG, 10'($urandom)}, $urandom_range(0, 5) == 0);
            end else begin
                u = {($urandom_range(0, 1) != 0) ? HIGH_SURR_TAG : LOW_SURR_TAG, 10'($urandom)};
                send_unit(u, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic test_random_streams();
        logic [1:0] plan [8];
        int         p;
        plan = '{c2u_pkg::MODE_UTF16, c2u_pkg::MODE_EBU, c2u_pkg::MODE_PASS,
                 c2u_pkg::MODE_UTF16, MODE_ALIAS, c2u_pkg::MODE_EBU,
                 c2u_pkg::MODE_UTF16, c2u_pkg::MODE_PASS};
        for (p = 0; p < 8; p++) begin
            // one quiet phase in the middle, none at all at the end
            idle_en = (p != 3) && (p != 7);
            write_mode(plan[p]);
            if (plan[p] == c2u_pkg::MODE_UTF16) begin
                random_utf16_units(26);
            end else begin
                random_byte_units(18);
            end
        end
    endtask

    initial begin
        int w;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_code_unit = '0;
        i_last_unit = 1'b0;
        idle_en     = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ebu_table();
        test_utf16_pairs();
        test_surrogate_errors();
        test_held_across_modes();
        test_passthrough();
        test_mode_alias();
        test_random_streams();

        i_in_valid <= 1'b0;
        for (w = 0; w < 2000 && expected_bytes.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            $display("%0d expected bytes never came out", expected_bytes.size());
        end
        $display("covered %0d units over EBU Latin, UTF-16, passthrough and mode 3 settings",
                 units_sent);
        $display("checked %0d output bytes, %0d of them surrogate errors; %0d mismatches",
                 bytes_checked, error_results, mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
